// ===== rtl/wfpd_pkg.sv =====
// Shared types, widths and constants of the wall-follow PID drive unit.
package wfpd_pkg;

   localparam int MM_W        = 16;
   localparam int ERR_W       = 20;
   localparam int SUM_W       = 40;
   localparam int SPEED_W     = 32;
   localparam int GAIN_W      = 16;
   localparam int TERM_W      = 21;
   localparam int PROD_W      = GAIN_W + TERM_W;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;

   // The accumulated PID sum and its scaled magnitude.
   localparam int ACC_W       = 58;
   localparam int SCALE_SHIFT = 4;
   localparam int MAG_W       = 44;

   // Division by 625, one 11-bit quotient digit per two stages.
   localparam int DIGIT_W    = 11;
   localparam int NUM_DIGITS = MAG_W / DIGIT_W;
   localparam int REM_W      = 10;
   localparam int DIV_X_W    = REM_W + DIGIT_W;
   localparam int DIV_STAGES = 2 * NUM_DIGITS;
   localparam int DIVISOR    = 625;
   localparam int DIV_SHIFT  = 31;
   localparam int MAGIC_W    = 22;
   localparam logic [MAGIC_W-1:0] DIV_MAGIC = 22'd3435974;

   localparam logic [MM_W-1:0] OPEN_MM   = 16'd1000;
   localparam logic [MM_W-1:0] CLOSED_MM = 16'd0;

   localparam logic signed [GAIN_W-1:0]  GAIN_P_RESET     = 16'sd384;
   localparam logic signed [GAIN_W-1:0]  GAIN_I_RESET     = 16'sd3;
   localparam logic signed [GAIN_W-1:0]  GAIN_D_RESET     = 16'sd0;
   localparam logic signed [SPEED_W-1:0] BASE_SPEED_RESET = 32'sd131072;
   localparam logic [MM_W-1:0]           SIDE_OPEN_RESET  = 16'd400;
   localparam logic [MM_W-1:0]           FRONT_OPEN_RESET = 16'd900;
   localparam logic [MM_W-1:0]           SIDES_OPEN_RESET = 16'd500;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAIN_P        = 3'd0,
      CSR_GAIN_I        = 3'd1,
      CSR_GAIN_D        = 3'd2,
      CSR_BASE_SPEED    = 3'd3,
      CSR_SIDE_OPEN_MM  = 3'd4,
      CSR_FRONT_OPEN_MM = 3'd5,
      CSR_SIDES_OPEN_MM = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [MM_W-1:0] right_mm;
      logic [MM_W-1:0] front_right_mm;
      logic [MM_W-1:0] front_left_mm;
      logic [MM_W-1:0] left_mm;
   } req_word_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] right_speed;
      logic signed [SPEED_W-1:0] left_speed;
      logic signed [ERR_W-1:0]   steer_error;
   } rsp_word_type;

   // Travels with a word through the divider.
   typedef struct packed {
      logic                    neg;
      logic                    big;
      logic signed [ERR_W-1:0] steer_error;
   } div_tag_type;

endpackage

// ===== rtl/wfpd_stream_if.sv =====
// Valid/ready stream channel carrying one word per handshake.
interface wfpd_stream_if #(parameter type word_type = logic);

   logic     valid;
   logic     ready;
   word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

// ===== rtl/wfpd_term_lane.sv =====
// One PID term lane: a registered signed gain-by-term product.
module wfpd_term_lane (
   input  logic                                    clock,
   input  logic                                    load,
   input  logic signed [wfpd_pkg::GAIN_W-1:0]      gain,
   input  logic signed [wfpd_pkg::TERM_W-1:0]      term,
   output logic signed [wfpd_pkg::PROD_W-1:0]      product_ff
);
   import wfpd_pkg::*;

   logic signed [PROD_W-1:0] product_in;

   assign product_in = PROD_W'(gain) * PROD_W'(term);

   always_ff @(posedge clock) begin
      if (load) begin
         product_ff <= product_in;
      end
   end

endmodule

// ===== rtl/wfpd_div625.sv =====
// Pipelined division of the scaled drive magnitude by 625, one digit per stage pair.
module wfpd_div625 (
   input  logic                                clock,
   input  logic [wfpd_pkg::DIV_STAGES-1:0]     stage_en,
   input  logic [wfpd_pkg::MAG_W-1:0]          dividend,
   input  wfpd_pkg::div_tag_type               tag_in,
   output logic [wfpd_pkg::MAG_W-1:0]          quotient,
   output logic [wfpd_pkg::REM_W-1:0]          remainder,
   output wfpd_pkg::div_tag_type               tag_out
);
   import wfpd_pkg::*;

   localparam int PROD_X_W = DIV_X_W + MAGIC_W;

   logic [REM_W-1:0] rem_src  [NUM_DIGITS+1];
   logic [MAG_W-1:0] num_src  [NUM_DIGITS];
   logic [MAG_W-1:0] quot_src [NUM_DIGITS+1];
   div_tag_type      tag_src  [NUM_DIGITS+1];

   assign rem_src[0]  = '0;
   assign num_src[0]  = dividend;
   assign quot_src[0] = '0;
   assign tag_src[0]  = tag_in;

   for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_digit
      logic [DIV_X_W-1:0]  x_in;
      logic [DIV_X_W-1:0]  x_ff;
      logic [PROD_X_W-1:0] recip_prod;
      logic [DIGIT_W-1:0]  q_in;
      logic [DIGIT_W-1:0]  q_ff;
      logic [MAG_W-1:0]    quot_a_ff;
      logic [MAG_W-1:0]    quot_b_ff;
      div_tag_type         tag_a_ff;
      div_tag_type         tag_b_ff;
      logic [DIV_X_W-1:0]  rem_in;
      logic [REM_W-1:0]    rem_ff;

      // The partial remainder is below 625, so x stays below 625 * 2^11 and the
      // reciprocal product gives the exact floor quotient digit.
      assign x_in       = {rem_src[k], num_src[k][MAG_W-1-k*DIGIT_W -: DIGIT_W]};
      assign recip_prod = PROD_X_W'(x_in) * PROD_X_W'(DIV_MAGIC);
      assign q_in       = recip_prod[DIV_SHIFT +: DIGIT_W];

      always_ff @(posedge clock) begin
         if (stage_en[2*k]) begin
            x_ff      <= x_in;
            q_ff      <= q_in;
            quot_a_ff <= quot_src[k];
            tag_a_ff  <= tag_src[k];
         end
      end

      assign rem_in = x_ff - DIV_X_W'(DIVISOR) * DIV_X_W'(q_ff);

      always_ff @(posedge clock) begin
         if (stage_en[2*k+1]) begin
            rem_ff    <= rem_in[REM_W-1:0];
            quot_b_ff <= {quot_a_ff[MAG_W-DIGIT_W-1:0], q_ff};
            tag_b_ff  <= tag_a_ff;
         end
      end

      assign rem_src[k+1]  = rem_ff;
      assign quot_src[k+1] = quot_b_ff;
      assign tag_src[k+1]  = tag_b_ff;

      if (k < NUM_DIGITS - 1) begin : g_carry
         logic [MAG_W-1:0] num_a_ff;
         logic [MAG_W-1:0] num_b_ff;

         always_ff @(posedge clock) begin
            if (stage_en[2*k]) begin
               num_a_ff <= num_src[k];
            end
            if (stage_en[2*k+1]) begin
               num_b_ff <= num_a_ff;
            end
         end

         assign num_src[k+1] = num_b_ff;
      end
   end

   assign quotient  = quot_src[NUM_DIGITS];
   assign remainder = rem_src[NUM_DIGITS];
   assign tag_out   = tag_src[NUM_DIGITS];

endmodule

// ===== rtl/wall_follow_pid_drive_unit.sv =====
// Top level of the wall-follow PID drive unit: override rules, error, PID lanes, drive, speeds.
//
// The unit takes one word of four sonar distances per clock cycle unless the pipeline is full and
// the output side is not ready, and returns one word of wheel speeds and steering error for each,
// in order. The rate is set by the integrator, a single 40-bit saturating add; the unit as a whole
// is a 16-stage pipeline: override and error, integrator, four parallel gain lanes (proportional,
// derivative, and the integral split into two 20-bit halves), a two-stage merging adder,
// magnitude, an eight-stage divide-by-625 and the speed saturation. Stalled words close up inside
// the pipeline, so input words are still taken while a result waits at the output. The user must
// write registers through the csr port only while the unit holds no word; the unit does not
// enforce this. There is no start-up pass.
module wall_follow_pid_drive_unit (
   input  logic                                clock,
   input  logic                                reset,
   wfpd_stream_if.sink                         req_chan,
   wfpd_stream_if.source                       rsp_chan,
   input  logic                                csr_we,
   input  logic [wfpd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [wfpd_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import wfpd_pkg::*;

   localparam int ST_ERR     = 0;
   localparam int ST_SUM     = 1;
   localparam int ST_LANE    = 2;
   localparam int ST_PART    = 3;
   localparam int ST_ACC     = 4;
   localparam int ST_MAG     = 5;
   localparam int ST_DIV     = 6;
   localparam int ST_DRIVE   = ST_DIV + DIV_STAGES;
   localparam int ST_OUT     = ST_DRIVE + 1;
   localparam int NUM_STAGES = ST_OUT + 1;

   localparam int NUM_LANES = 4;
   localparam int LANE_P    = 0;
   localparam int LANE_D    = 1;
   localparam int LANE_I_LO = 2;
   localparam int LANE_I_HI = 3;
   localparam int SUM_SPLIT = SUM_W / 2;
   localparam int PD_W      = PROD_W + 1;
   localparam int DERIV_W   = ERR_W + 1;
   localparam int LIM_W     = 34;
   localparam int DRIVE_W   = LIM_W + 1;
   localparam int SPD_SUM_W = DRIVE_W + 1;
   localparam logic [MAG_W-1:0] DRIVE_LIM = MAG_W'(1) << (LIM_W - 1);

   function automatic logic signed [SPEED_W-1:0] sat_speed(
      input logic signed [SPD_SUM_W-1:0] v
   );
      logic fits;
      fits = (v[SPD_SUM_W-1:SPEED_W-1] == '0) || (&v[SPD_SUM_W-1:SPEED_W-1]);
      if (fits) begin
         return v[SPEED_W-1:0];
      end
      return {v[SPD_SUM_W-1], {(SPEED_W-1){~v[SPD_SUM_W-1]}}};
   endfunction

   // ---------------- configuration registers ----------------
   logic signed [GAIN_W-1:0]  gain_p_ff;
   logic signed [GAIN_W-1:0]  gain_i_ff;
   logic signed [GAIN_W-1:0]  gain_d_ff;
   logic signed [SPEED_W-1:0] base_speed_ff;
   logic [MM_W-1:0]           side_open_ff;
   logic [MM_W-1:0]           front_open_ff;
   logic [MM_W-1:0]           sides_open_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff     <= GAIN_P_RESET;
         gain_i_ff     <= GAIN_I_RESET;
         gain_d_ff     <= GAIN_D_RESET;
         base_speed_ff <= BASE_SPEED_RESET;
         side_open_ff  <= SIDE_OPEN_RESET;
         front_open_ff <= FRONT_OPEN_RESET;
         sides_open_ff <= SIDES_OPEN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GAIN_P:        gain_p_ff     <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_I:        gain_i_ff     <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_D:        gain_d_ff     <= csr_wdata[GAIN_W-1:0];
            CSR_BASE_SPEED:    base_speed_ff <= csr_wdata[SPEED_W-1:0];
            CSR_SIDE_OPEN_MM:  side_open_ff  <= csr_wdata[MM_W-1:0];
            CSR_FRONT_OPEN_MM: front_open_ff <= csr_wdata[MM_W-1:0];
            CSR_SIDES_OPEN_MM: sides_open_ff <= csr_wdata[MM_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline flow control ----------------
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] valid_prev;
   logic [NUM_STAGES-1:0] stage_en;

   // A stage may load when some stage at or after it is empty or the output drains.
   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage_en
      assign stage_en[i] = rsp_chan.ready | ~(&valid_ff[NUM_STAGES-1:i]);
   end

   assign valid_prev = {valid_ff[NUM_STAGES-2:0], req_chan.valid};
   assign valid_in   = (stage_en & valid_prev) | (~stage_en & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_chan.ready = stage_en[ST_ERR];

   // ---------------- override rules and steering error ----------------
   logic [MM_W-1:0] r_mm;
   logic [MM_W-1:0] fr_mm;
   logic [MM_W-1:0] fl_mm;
   logic [MM_W-1:0] l_mm;
   logic            rule_one;
   logic            rule_two;
   logic            rule_three;
   logic signed [ERR_W-1:0] side_diff;
   logic signed [ERR_W-1:0] front_diff;
   logic signed [ERR_W-1:0] err_in;
   logic signed [ERR_W-1:0] err_ff [ST_MAG];

   assign rule_one = (req_chan.data.front_left_mm > req_chan.data.front_right_mm) &&
                     (req_chan.data.left_mm > side_open_ff);
   assign rule_two = (req_chan.data.front_left_mm > front_open_ff) &&
                     (req_chan.data.front_right_mm > front_open_ff) &&
                     (req_chan.data.left_mm > sides_open_ff) &&
                     (req_chan.data.right_mm > sides_open_ff);
   assign rule_three = (req_chan.data.front_right_mm > req_chan.data.front_left_mm) ||
                       (req_chan.data.left_mm < req_chan.data.right_mm);

   always_comb begin
      r_mm  = req_chan.data.right_mm;
      fr_mm = req_chan.data.front_right_mm;
      fl_mm = req_chan.data.front_left_mm;
      l_mm  = req_chan.data.left_mm;
      if (rule_one) begin
         r_mm  = CLOSED_MM;
         fr_mm = CLOSED_MM;
         fl_mm = OPEN_MM;
         l_mm  = OPEN_MM;
      end else if (rule_two) begin
         r_mm  = CLOSED_MM;
         fr_mm = OPEN_MM;
         fl_mm = OPEN_MM;
         l_mm  = CLOSED_MM;
      end else if (rule_three) begin
         r_mm  = OPEN_MM;
         fr_mm = OPEN_MM;
         fl_mm = CLOSED_MM;
         l_mm  = CLOSED_MM;
      end
   end

   assign side_diff  = $signed(ERR_W'(l_mm)) - $signed(ERR_W'(r_mm));
   assign front_diff = $signed(ERR_W'(fl_mm)) - $signed(ERR_W'(fr_mm));
   assign err_in     = (side_diff <<< 2) + side_diff + (front_diff <<< 1);

   always_ff @(posedge clock) begin
      if (stage_en[ST_ERR]) begin
         err_ff[0] <= err_in;
      end
      for (int i = 1; i < ST_MAG; i++) begin
         if (stage_en[i]) begin
            err_ff[i] <= err_ff[i-1];
         end
      end
   end

   // ---------------- integrator and derivative ----------------
   logic signed [ERR_W-1:0]   prior_error_ff;
   logic signed [SUM_W-1:0]   error_sum_ff;
   logic signed [SUM_W:0]     sum_wide;
   logic signed [SUM_W-1:0]   error_sum_in;
   logic signed [DERIV_W-1:0] deriv_in;
   logic signed [DERIV_W-1:0] deriv_ff;
   logic signed [SUM_W-1:0]   sum_stage_ff;
   logic                      sum_advance;

   assign sum_advance = stage_en[ST_SUM] & valid_ff[ST_ERR];
   assign sum_wide    = (SUM_W+1)'(error_sum_ff) + (SUM_W+1)'(err_ff[ST_ERR]);
   assign error_sum_in = (sum_wide[SUM_W] == sum_wide[SUM_W-1]) ? sum_wide[SUM_W-1:0] :
                         {sum_wide[SUM_W], {(SUM_W-1){~sum_wide[SUM_W]}}};
   assign deriv_in    = DERIV_W'(err_ff[ST_ERR]) - DERIV_W'(prior_error_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         prior_error_ff <= '0;
         error_sum_ff   <= '0;
      end else if (sum_advance) begin
         prior_error_ff <= err_ff[ST_ERR];
         error_sum_ff   <= error_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_SUM]) begin
         deriv_ff     <= deriv_in;
         sum_stage_ff <= error_sum_in;
      end
   end

   // ---------------- gain lanes ----------------
   logic signed [GAIN_W-1:0] lane_gain [NUM_LANES];
   logic signed [TERM_W-1:0] lane_term [NUM_LANES];
   logic signed [PROD_W-1:0] lane_prod [NUM_LANES];

   assign lane_gain[LANE_P]    = gain_p_ff;
   assign lane_gain[LANE_D]    = gain_d_ff;
   assign lane_gain[LANE_I_LO] = gain_i_ff;
   assign lane_gain[LANE_I_HI] = gain_i_ff;

   assign lane_term[LANE_P]    = TERM_W'(err_ff[ST_SUM]);
   assign lane_term[LANE_D]    = deriv_ff;
   assign lane_term[LANE_I_LO] = $signed({1'b0, sum_stage_ff[SUM_SPLIT-1:0]});
   assign lane_term[LANE_I_HI] = TERM_W'($signed(sum_stage_ff[SUM_W-1:SUM_SPLIT]));

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      wfpd_term_lane u_lane (
         .clock      (clock),
         .load       (stage_en[ST_LANE]),
         .gain       (lane_gain[g]),
         .term       (lane_term[g]),
         .product_ff (lane_prod[g])
      );
   end

   // ---------------- merging adder ----------------
   logic signed [PD_W-1:0]  part_pd_ff;
   logic signed [ACC_W-1:0] part_i_ff;
   logic signed [ACC_W-1:0] acc_ff;

   always_ff @(posedge clock) begin
      if (stage_en[ST_PART]) begin
         part_pd_ff <= PD_W'(lane_prod[LANE_P]) + PD_W'(lane_prod[LANE_D]);
         part_i_ff  <= (ACC_W'(lane_prod[LANE_I_HI]) <<< SUM_SPLIT) +
                       ACC_W'(lane_prod[LANE_I_LO]);
      end
      if (stage_en[ST_ACC]) begin
         acc_ff <= part_i_ff + ACC_W'(part_pd_ff);
      end
   end

   // ---------------- magnitude and scaling ----------------
   logic [ACC_W-1:0] acc_mag;
   logic [MAG_W-1:0] num_ff;
   div_tag_type      tag_ff;

   assign acc_mag = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);

   // A magnitude of 2^40 or more drives both speeds into saturation whatever the base.
   always_ff @(posedge clock) begin
      if (stage_en[ST_MAG]) begin
         num_ff             <= {acc_mag[MAG_W-SCALE_SHIFT-1:0], {SCALE_SHIFT{1'b0}}};
         tag_ff.neg         <= acc_ff[ACC_W-1];
         tag_ff.big         <= |acc_mag[ACC_W-1:MAG_W-SCALE_SHIFT];
         tag_ff.steer_error <= err_ff[ST_ACC];
      end
   end

   logic [MAG_W-1:0] div_quot;
   logic [REM_W-1:0] div_rem;
   div_tag_type      div_tag;

   wfpd_div625 u_div (
      .clock     (clock),
      .stage_en  (stage_en[ST_DIV +: DIV_STAGES]),
      .dividend  (num_ff),
      .tag_in    (tag_ff),
      .quotient  (div_quot),
      .remainder (div_rem),
      .tag_out   (div_tag)
   );

   // ---------------- drive and wheel speeds ----------------
   logic                      drive_over;
   logic [LIM_W-1:0]          drive_mag;
   logic signed [DRIVE_W-1:0] drive_in;
   logic signed [DRIVE_W-1:0] drive_ff;
   logic signed [ERR_W-1:0]   drive_err_ff;
   logic signed [SPD_SUM_W-1:0] right_sum;
   logic signed [SPD_SUM_W-1:0] left_sum;
   rsp_word_type              rsp_in;
   rsp_word_type              rsp_ff;

   assign drive_over = div_tag.big || (div_quot > DRIVE_LIM);
   assign drive_mag  = drive_over ? DRIVE_LIM[LIM_W-1:0] : div_quot[LIM_W-1:0];
   assign drive_in   = div_tag.neg ? -$signed({1'b0, drive_mag}) : $signed({1'b0, drive_mag});

   always_ff @(posedge clock) begin
      if (stage_en[ST_DRIVE]) begin
         drive_ff     <= drive_in;
         drive_err_ff <= div_tag.steer_error;
      end
   end

   assign right_sum = SPD_SUM_W'(base_speed_ff) + SPD_SUM_W'(drive_ff);
   assign left_sum  = SPD_SUM_W'(base_speed_ff) - SPD_SUM_W'(drive_ff);

   always_comb begin
      rsp_in.right_speed = sat_speed(right_sum);
      rsp_in.left_speed  = sat_speed(left_sum);
      rsp_in.steer_error = drive_err_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_OUT]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid = valid_ff[ST_OUT];
   assign rsp_chan.data  = rsp_ff;

   // ---------------- assertions ----------------
   a_ready_when_room: assert property (@(posedge clock) disable iff (reset)
      !(&valid_ff) |-> req_chan.ready)
      else $error("input stalled although the pipeline has an empty stage");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> valid_ff[ST_ERR])
      else $error("accepted word did not enter the first stage");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      valid_ff[ST_DRIVE-1] |-> (div_rem < REM_W'(DIVISOR)))
      else $error("divider remainder out of range");

   a_speed_sides: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !((rsp_chan.data.right_speed > base_speed_ff) &&
                           (rsp_chan.data.left_speed > base_speed_ff)))
      else $error("both wheel speeds above base speed");

endmodule

// ===== test/wall_follow_pid_drive_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the wall-follow PID drive unit: directed rows, then random phases.
module wall_follow_pid_drive_unit_tb;
   import wfpd_pkg::*;

   localparam int HALF_PERIOD    = 4;
   localparam int RESET_CYCLES   = 12;
   localparam int MAX_GAP        = 10;
   localparam int LONG_HOLD      = 300;
   localparam int STALL_LIMIT    = 2000;
   localparam int DRAIN_CYCLES   = 24;
   localparam int NUM_PHASES     = 8;
   localparam int PHASE_ITEMS    = 190;
   localparam int PRESSURE_PHASE = 4;
   localparam int STEADY_PHASE   = 5;
   localparam int DRIVE_NUM      = 32;
   localparam int DRIVE_DEN      = 1250;
   localparam logic [CSR_INDEX_W-1:0] CSR_NO_REG = 3'd7;
   localparam longint SUM_HI   = 64'sd549755813887;
   localparam longint SUM_LO   = -64'sd549755813888;
   localparam longint SPEED_HI = 64'sd2147483647;
   localparam longint SPEED_LO = -64'sd2147483648;
   localparam longint MM_HI    = 64'sd65535;

   typedef enum logic {ROW_READING, ROW_REG_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [CSR_DATA_W-1:0]  reg_data;
      req_word_type           word;
      logic                   known;
      rsp_word_type           answer;
   } drill_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   wfpd_stream_if #(.word_type(req_word_type)) req_if ();
   wfpd_stream_if #(.word_type(rsp_word_type)) rsp_if ();

   wall_follow_pid_drive_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Shadow copy of the registers and of the controller state.
   longint k_prop       = GAIN_P_RESET;
   longint k_int        = GAIN_I_RESET;
   longint k_deriv      = GAIN_D_RESET;
   longint cruise_speed = BASE_SPEED_RESET;
   longint side_gap_mm  = SIDE_OPEN_RESET;
   longint front_gap_mm = FRONT_OPEN_RESET;
   longint sides_gap_mm = SIDES_OPEN_RESET;
   longint last_error   = 0;
   longint error_total  = 0;

   rsp_word_type pending_speeds [$];
   int           mismatches        = 0;
   int           idle_cycles       = 0;
   bit           steady            = 1'b0;
   bit           long_hold_pending = 1'b0;

   localparam int NUM_DRILL = 27;
   drill_row_type drill_rows [NUM_DRILL] = '{
      // Fresh from reset the default gains see a zero error.
      '{ROW_READING, CSR_NO_REG, 32'd0, '{16'd0, 16'd0, 16'd0, 16'd0},
        1'b1, '{32'sd131072, 32'sd131072, 20'sd0}},
      '{ROW_READING, CSR_NO_REG, 32'd0, '{16'd0, 16'd0, 16'd1, 16'd65535}, 1'b0, '0},
      '{ROW_READING, CSR_NO_REG, 32'd0, '{16'd600, 16'd950, 16'd950, 16'd600}, 1'b0, '0},
      '{ROW_READING, CSR_NO_REG, 32'd0, '{16'd0, 16'd1, 16'd0, 16'd0}, 1'b0, '0},
      '{ROW_READING, CSR_NO_REG, 32'd0, '{16'd5, 16'd0, 16'd0, 16'd4}, 1'b0, '0},
      '{ROW_READING, CSR_NO_REG, 32'd0, '{16'd0, 16'd0, 16'd0, 16'd65535}, 1'b0, '0},
      '{ROW_READING, CSR_NO_REG, 32'd0, '{16'd65535, 16'd65535, 16'd65535, 16'd65535},
        1'b0, '0},
      '{ROW_READING, CSR_NO_REG, 32'd0, '{16'd0, 16'd0, 16'd1, 16'd400}, 1'b0, '0},
      '{ROW_READING, CSR_NO_REG, 32'd0, '{16'd0, 16'd0, 16'd1, 16'd401}, 1'b0, '0},
      '{ROW_READING, CSR_NO_REG, 32'd0, '{16'd501, 16'd901, 16'd901, 16'd501}, 1'b0, '0},
      '{ROW_READING, CSR_NO_REG, 32'd0, '{16'd500, 16'd901, 16'd901, 16'd501}, 1'b0, '0},
      '{ROW_READING, CSR_NO_REG, 32'd0, '{16'd65535, 16'd0, 16'd0, 16'd0}, 1'b0, '0},
      '{ROW_REG_WRITE, CSR_GAIN_P, 32'h0000_0000, '0, 1'b0, '0},
      '{ROW_REG_WRITE, CSR_GAIN_I, 32'hABCD_0000, '0, 1'b0, '0},
      '{ROW_REG_WRITE, CSR_GAIN_D, 32'hFFFF_0000, '0, 1'b0, '0},
      '{ROW_REG_WRITE, CSR_BASE_SPEED, 32'h7FFF_FFFF, '0, 1'b0, '0},
      // A write to the unused index must leave every register alone.
      '{ROW_REG_WRITE, CSR_NO_REG, 32'hFFFF_FFFF, '0, 1'b0, '0},
      '{ROW_READING, CSR_NO_REG, 32'd0, '{16'd0, 16'd0, 16'd0, 16'd0},
        1'b1, '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 20'sd0}},
      '{ROW_READING, CSR_NO_REG, 32'd0, '{16'd0, 16'd0, 16'd1, 16'd65535},
        1'b1, '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 20'sd7000}},
      '{ROW_READING, CSR_NO_REG, 32'd0, '{16'd0, 16'd1, 16'd0, 16'd0},
        1'b1, '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -20'sd7000}},
      '{ROW_REG_WRITE, CSR_GAIN_P, 32'h0000_7FFF, '0, 1'b0, '0},
      '{ROW_READING, CSR_NO_REG, 32'd0, '{16'd0, 16'd0, 16'd0, 16'd65535}, 1'b0, '0},
      '{ROW_REG_WRITE, CSR_BASE_SPEED, 32'h8000_0000, '0, 1'b0, '0},
      '{ROW_REG_WRITE, CSR_GAIN_P, 32'h0000_8000, '0, 1'b0, '0},
      '{ROW_READING, CSR_NO_REG, 32'd0, '{16'd0, 16'd0, 16'd0, 16'd65535}, 1'b0, '0},
      '{ROW_REG_WRITE, CSR_GAIN_D, 32'h0000_0001, '0, 1'b0, '0},
      '{ROW_READING, CSR_NO_REG, 32'd0, '{16'd0, 16'd1, 16'd0, 16'd0}, 1'b0, '0}
   };

   function automatic longint clamp_speed(input longint v);
      if (v > SPEED_HI) return SPEED_HI;
      if (v < SPEED_LO) return SPEED_LO;
      return v;
   endfunction

   // Override rules, weighted error, PID sum and the two wheel speeds of one reading.
   function automatic rsp_word_type predict_drive(input req_word_type w);
      longint       r, fr, fl, l, err, acc, drive;
      rsp_word_type y;
      r  = w.right_mm;
      fr = w.front_right_mm;
      fl = w.front_left_mm;
      l  = w.left_mm;
      if (fl > fr && l > side_gap_mm) begin
         r = CLOSED_MM; fr = CLOSED_MM; fl = OPEN_MM; l = OPEN_MM;
      end else if (fl > front_gap_mm && fr > front_gap_mm &&
                   l > sides_gap_mm && r > sides_gap_mm) begin
         r = CLOSED_MM; fr = OPEN_MM; fl = OPEN_MM; l = CLOSED_MM;
      end else if (fr > fl || l < r) begin
         r = OPEN_MM; fr = OPEN_MM; fl = CLOSED_MM; l = CLOSED_MM;
      end
      err = 5 * (l - r) + 2 * (fl - fr);
      error_total = error_total + err;
      if (error_total > SUM_HI) error_total = SUM_HI;
      if (error_total < SUM_LO) error_total = SUM_LO;
      acc = k_prop * err + k_int * error_total + k_deriv * (err - last_error);
      // Division of signed integers truncates toward zero.
      drive = (acc * DRIVE_NUM) / DRIVE_DEN;
      last_error = err;
      y.right_speed = SPEED_W'(clamp_speed(cruise_speed + drive));
      y.left_speed  = SPEED_W'(clamp_speed(cruise_speed - drive));
      y.steer_error = ERR_W'(err);
      return y;
   endfunction

   function automatic logic [MM_W-1:0] near_mm(input longint mark);
      longint v;
      v = mark + longint'($urandom_range(0, 4)) - 2;
      if (v < 0) v = 0;
      if (v > MM_HI) v = MM_HI;
      return MM_W'(v);
   endfunction

   function automatic logic [MM_W-1:0] extreme_mm();
      case ($urandom_range(0, 4))
         0:       return 16'd0;
         1:       return 16'd1;
         2:       return OPEN_MM;
         3:       return 16'd65534;
         default: return 16'd65535;
      endcase
   endfunction

   // Most readings are aimed at the rule boundaries; the rest are plain noise.
   function automatic req_word_type random_reading();
      req_word_type w;
      w = req_word_type'({$urandom, $urandom});
      case ($urandom_range(0, 9))
         3, 4: begin
            // Level fronts and the left no nearer than the right: no rule but the second fires.
            w.front_left_mm = w.front_right_mm;
            w.left_mm       = MM_W'($urandom_range(w.right_mm, 16'hFFFF));
         end
         5: begin
            w.front_right_mm = near_mm(front_gap_mm);
            w.front_left_mm  = near_mm(front_gap_mm);
            w.right_mm       = near_mm(sides_gap_mm);
            w.left_mm        = near_mm(sides_gap_mm);
         end
         6: begin
            w.front_left_mm = w.front_right_mm + MM_W'($urandom_range(0, 1));
            w.left_mm       = near_mm(side_gap_mm);
         end
         7: begin
            w.right_mm       = MM_W'($urandom_range(0, 1200));
            w.front_right_mm = MM_W'($urandom_range(0, 1200));
            w.front_left_mm  = MM_W'($urandom_range(0, 1200));
            w.left_mm        = MM_W'($urandom_range(0, 1200));
         end
         8: begin
            w.right_mm       = extreme_mm();
            w.front_right_mm = extreme_mm();
            w.front_left_mm  = extreme_mm();
            w.left_mm        = extreme_mm();
         end
         9: begin
            w.front_left_mm = w.front_right_mm;
            w.left_mm       = near_mm(w.right_mm);
         end
         default: ;
      endcase
      return w;
   endfunction

   task automatic send_reading(input req_word_type w, input logic known,
                               input rsp_word_type answer);
      int           gap;
      rsp_word_type want;
      gap = steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= w;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      want = predict_drive(w);
      pending_speeds.push_back(known ? answer : want);
   endtask

   // The caller lowers the write enable once the last register of a batch is written.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_GAIN_P:        k_prop       = $signed(data[GAIN_W-1:0]);
         CSR_GAIN_I:        k_int        = $signed(data[GAIN_W-1:0]);
         CSR_GAIN_D:        k_deriv      = $signed(data[GAIN_W-1:0]);
         CSR_BASE_SPEED:    cruise_speed = $signed(data[SPEED_W-1:0]);
         CSR_SIDE_OPEN_MM:  side_gap_mm  = data[MM_W-1:0];
         CSR_FRONT_OPEN_MM: front_gap_mm = data[MM_W-1:0];
         CSR_SIDES_OPEN_MM: sides_gap_mm = data[MM_W-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_quiet();
      req_if.valid <= 1'b0;
      csr_we       <= 1'b0;
      while (pending_speeds.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   function automatic void compare_field(input string name, input logic [SPEED_W-1:0] want,
                                         input logic [SPEED_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %0d, got %0d", $time, name, $signed(want), $signed(got));
      end
   endfunction

   function automatic void check_speeds(input rsp_word_type got);
      rsp_word_type want;
      if (pending_speeds.size() == 0) begin
         mismatches++;
         $display("%0t: word %h arrived with nothing expected", $time, got);
         return;
      end
      want = pending_speeds.pop_front();
      compare_field("right_speed", want.right_speed, got.right_speed);
      compare_field("left_speed", want.left_speed, got.left_speed);
      compare_field("steer_error", SPEED_W'(want.steer_error), SPEED_W'(got.steer_error));
   endfunction

   initial begin
      logic [GAIN_W-1:0]  gp, gi, gd;
      logic [SPEED_W-1:0] base;
      logic [MM_W-1:0]    side_open, front_open, sides_open;
      reset        <= 1'b1;
      csr_we       <= 1'b0;
      csr_index    <= '0;
      csr_wdata    <= '0;
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (drill_rows[i]) begin
         if (drill_rows[i].kind == ROW_REG_WRITE) begin
            wait_quiet();
            write_reg(drill_rows[i].reg_index, drill_rows[i].reg_data);
         end else begin
            csr_we <= 1'b0;
            send_reading(drill_rows[i].word, drill_rows[i].known, drill_rows[i].answer);
         end
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin
               gp = GAIN_P_RESET; gi = GAIN_I_RESET; gd = GAIN_D_RESET;
               base = BASE_SPEED_RESET;
               side_open = SIDE_OPEN_RESET; front_open = FRONT_OPEN_RESET;
               sides_open = SIDES_OPEN_RESET;
            end
            1: begin
               gp = 16'h7FFF; gi = 16'h7FFF; gd = 16'h7FFF; base = 32'h7FFF_FFFF;
               side_open = 16'hFFFF; front_open = 16'hFFFF; sides_open = 16'hFFFF;
            end
            2: begin
               gp = 16'h8000; gi = 16'h8000; gd = 16'h8000; base = 32'h8000_0000;
               side_open = 16'h0000; front_open = 16'h0000; sides_open = 16'h0000;
            end
            default: begin
               // Mostly modest gains so the speeds stay clear of saturation.
               gp = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 1200) - 600);
               gi = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 1200) - 600);
               gd = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 1200) - 600);
               base = ($urandom_range(0, 2) == 0) ? $urandom
                                                  : $urandom_range(0, 33554432) - 32'd16777216;
               side_open  = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(0, 2000));
               front_open = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(0, 2000));
               sides_open = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(0, 2000));
            end
         endcase
         wait_quiet();
         // The unused upper bits of the narrow registers carry noise.
         write_reg(CSR_GAIN_P, {16'($urandom), gp});
         write_reg(CSR_GAIN_I, {16'($urandom), gi});
         write_reg(CSR_GAIN_D, {16'($urandom), gd});
         write_reg(CSR_BASE_SPEED, base);
         write_reg(CSR_SIDE_OPEN_MM, {16'($urandom), side_open});
         write_reg(CSR_FRONT_OPEN_MM, {16'($urandom), front_open});
         write_reg(CSR_SIDES_OPEN_MM, {16'($urandom), sides_open});
         csr_we <= 1'b0;
         steady = (phase == STEADY_PHASE);
         if (phase == PRESSURE_PHASE) long_hold_pending = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) send_reading(random_reading(), 1'b0, '0);
      end

      req_if.valid <= 1'b0;
      while (pending_speeds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("wall_follow_pid_drive_unit_tb passed");
      end else begin
         $display("wall_follow_pid_drive_unit_tb failed");
      end
      $finish;
   end

   // Result side: random back-pressure, and once a long hold so the pipeline fills and stalls.
   initial begin
      int hold;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_pending) begin
            hold = LONG_HOLD;
            long_hold_pending = 1'b0;
         end else begin
            hold = steady ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (hold > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         check_speeds(rsp_if.data);
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("wall_follow_pid_drive_unit_tb failed");
            $finish;
         end
      end
   end

endmodule
